@@ hdl/aaq_pkg.sv @@
// shared constants and tables for the axis-angle to quaternion pipeline
`default_nettype none
package aaq_pkg;

  localparam int AXIS_W = 16;
  localparam int ANGLE_W = 20;
  localparam int QUAT_W = 16;

  localparam int CORDIC_STAGES = 16;
  localparam int ATAN_LEN = 30;
  localparam int SQRT_STEPS = 32;
  localparam int QUO_BITS = 17;

  localparam logic [29:0] ATAN_Q30 [ATAN_LEN] = '{
    30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158, 30'd67021686,
    30'd33543515, 30'd16775850, 30'd8388437, 30'd4194282, 30'd2097149,
    30'd1048575, 30'd524287, 30'd262143, 30'd131071, 30'd65535,
    30'd32767, 30'd16383, 30'd8191, 30'd4095, 30'd2047,
    30'd1023, 30'd511, 30'd255, 30'd127, 30'd63,
    30'd31, 30'd15, 30'd7, 30'd3, 30'd1
  };

  localparam logic signed [33:0] PI_Q30 = 34'sd3373259426;
  localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [31:0] GAIN_Q30 = 32'sd652032874;
  localparam logic [16:0] ONE_Q14 = 17'd16384;

endpackage
`default_nettype wire

@@ hdl/aaq_if.sv @@
// channel interfaces: axis and angle in, quaternion out
`default_nettype none
interface aaq_cmd_if;
  logic valid;
  logic ready;
  logic signed [aaq_pkg::AXIS_W-1:0] axis_x;
  logic signed [aaq_pkg::AXIS_W-1:0] axis_y;
  logic signed [aaq_pkg::AXIS_W-1:0] axis_z;
  logic signed [aaq_pkg::ANGLE_W-1:0] rot_angle;
  modport source (output valid, axis_x, axis_y, axis_z, rot_angle, input ready);
  modport sink (input valid, axis_x, axis_y, axis_z, rot_angle, output ready);
endinterface

interface aaq_res_if;
  logic valid;
  logic ready;
  logic signed [aaq_pkg::QUAT_W-1:0] quat_x;
  logic signed [aaq_pkg::QUAT_W-1:0] quat_y;
  logic signed [aaq_pkg::QUAT_W-1:0] quat_z;
  logic signed [aaq_pkg::QUAT_W-1:0] quat_w;
  logic zero_axis;
  modport source (output valid, quat_x, quat_y, quat_z, quat_w, zero_axis, input ready);
  modport sink (input valid, quat_x, quat_y, quat_z, quat_w, zero_axis, output ready);
endinterface
`default_nettype wire

@@ hdl/axis_angle_to_quaternion.sv @@
// axis-angle to unit quaternion, fully pipelined top level
//
//   port   dir   payload                               meaning
//   cmd    sink  axis_x/y/z (s16), rot_angle (s20 Q4.16) rotation axis and angle
//   res    src   quat_x/y/z/w (s16 Q1.14), zero_axis   unit quaternion
//
// one item enters per cycle while the result side is not stalled
// pipe depth is set by the 32-step square root and the 17-step divide chains
// cordic steps run alongside the root steps, so they add no depth
// the whole pipe advances together; a stalled result holds every stage
// synchronous reset clears only the valid bits
`default_nettype none
module axis_angle_to_quaternion (
  input wire logic clk,
  input wire logic rst,
  aaq_cmd_if.sink cmd,
  aaq_res_if.source res
);

  localparam int NS = aaq_pkg::SQRT_STEPS;
  localparam int NQ = aaq_pkg::QUO_BITS;

  // front stage: inputs, squares, reduced half angle
  typedef struct packed {
    logic vld;
    logic flip;
    logic [2:0][15:0] a;
    logic [2:0][30:0] sq;
    logic signed [33:0] h;
  } fr_t;

  // iteration stages: cordic and square root side by side
  typedef struct packed {
    logic vld;
    logic flip;
    logic zero;
    logic [2:0][15:0] a;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [33:0] ch;
    logic [63:0] rv;
    logic [63:0] rr;
  } it_t;

  // products and rounded w
  typedef struct packed {
    logic vld;
    logic zero;
    logic [2:0][47:0] p;
    logic [15:0] w;
    logic [30:0] r;
  } pr_t;

  // divide stages
  typedef struct packed {
    logic vld;
    logic zero;
    logic [2:0] neg;
    logic [2:0][48:0] rem;
    logic [2:0][NQ-1:0] q;
    logic [32:0] dvs;
    logic [15:0] w;
  } dv_t;

  typedef struct packed {
    logic vld;
    logic zero;
    logic [3:0][15:0] q;
  } ot_t;

  logic en;
  fr_t fr;
  it_t it [NS+1];
  pr_t pr;
  dv_t dv [NQ+1];
  ot_t ot;

  assign en = !ot.vld || res.ready;
  assign cmd.ready = en;

  // front stage
  logic signed [33:0] h_raw;
  logic signed [33:0] h_red;
  logic flip_in;

  always_comb begin
    h_raw = 34'(cmd.rot_angle) <<< 13;
    h_red = h_raw;
    flip_in = 1'b0;
    if (h_raw > aaq_pkg::HALF_PI_Q30) begin
      h_red = h_raw - aaq_pkg::PI_Q30;
      flip_in = 1'b1;
    end else if (h_raw < -aaq_pkg::HALF_PI_Q30) begin
      h_red = h_raw + aaq_pkg::PI_Q30;
      flip_in = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fr.vld <= 1'b0;
    end else if (en) begin
      fr.vld <= cmd.valid;
      fr.flip <= flip_in;
      fr.a[0] <= cmd.axis_x;
      fr.a[1] <= cmd.axis_y;
      fr.a[2] <= cmd.axis_z;
      fr.sq[0] <= 31'(cmd.axis_x * cmd.axis_x);
      fr.sq[1] <= 31'(cmd.axis_y * cmd.axis_y);
      fr.sq[2] <= 31'(cmd.axis_z * cmd.axis_z);
      fr.h <= h_red;
    end
  end

  // sum of squares, start of the iteration chain
  logic [31:0] sum;
  assign sum = 32'(fr.sq[0]) + 32'(fr.sq[1]) + 32'(fr.sq[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      it[0].vld <= 1'b0;
    end else if (en) begin
      it[0].vld <= fr.vld;
      it[0].flip <= fr.flip;
      it[0].zero <= (sum == 32'd0);
      it[0].a <= fr.a;
      it[0].cx <= aaq_pkg::GAIN_Q30;
      it[0].cy <= 32'sd0;
      it[0].ch <= fr.h;
      it[0].rv <= {2'b00, sum, 30'd0};
      it[0].rr <= 64'd0;
    end
  end

  for (genvar k = 0; k < NS; k++) begin : g_it
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
    it_t nx;
    logic signed [31:0] cx_n;
    logic signed [31:0] cy_n;
    logic signed [33:0] ch_n;
    logic [63:0] t;

    if (k < aaq_pkg::CORDIC_STAGES) begin : g_cor
      logic signed [31:0] dx;
      logic signed [31:0] dy;
      logic signed [33:0] at;
      always_comb begin
        dx = $signed(it[k].cy) >>> k;
        dy = $signed(it[k].cx) >>> k;
        at = $signed({4'b0000, aaq_pkg::ATAN_Q30[k]});
        if ($signed(it[k].ch) >= 0) begin
          cx_n = $signed(it[k].cx) - dx;
          cy_n = $signed(it[k].cy) + dy;
          ch_n = $signed(it[k].ch) - at;
        end else begin
          cx_n = $signed(it[k].cx) + dx;
          cy_n = $signed(it[k].cy) - dy;
          ch_n = $signed(it[k].ch) + at;
        end
      end
    end else begin : g_hold
      assign cx_n = it[k].cx;
      assign cy_n = it[k].cy;
      assign ch_n = it[k].ch;
    end

    always_comb begin
      nx = it[k];
      nx.cx = cx_n;
      nx.cy = cy_n;
      nx.ch = ch_n;
      t = it[k].rr + BIT;
      if (it[k].rv >= t) begin
        nx.rv = it[k].rv - t;
        nx.rr = (it[k].rr >> 1) + BIT;
      end else begin
        nx.rr = it[k].rr >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        it[k+1].vld <= 1'b0;
      end else if (en) begin
        it[k+1] <= nx;
      end
    end
  end

  // sign fix, products, w rounding
  logic signed [31:0] cs;
  logic signed [31:0] ss;
  logic [31:0] cmag;
  logic [16:0] wr;
  logic [15:0] wcl;
  logic [2:0][47:0] pn;

  always_comb begin
    cs = it[NS].flip ? -$signed(it[NS].cx) : $signed(it[NS].cx);
    ss = it[NS].flip ? -$signed(it[NS].cy) : $signed(it[NS].cy);
    cmag = (cs < 0) ? 32'(-cs) : 32'(cs);
    wr = 17'((33'(cmag) + 33'd32768) >> 16);
    wcl = (wr > aaq_pkg::ONE_Q14) ? 16'(aaq_pkg::ONE_Q14) : wr[15:0];
    if (cs < 0) begin
      wcl = -wcl;
    end
    for (int i = 0; i < 3; i++) begin
      pn[i] = 48'(48'(ss) * 48'($signed(it[NS].a[i])));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pr.vld <= 1'b0;
    end else if (en) begin
      pr.vld <= it[NS].vld;
      pr.zero <= it[NS].zero;
      pr.p <= pn;
      pr.w <= wcl;
      pr.r <= it[NS].rr[30:0];
    end
  end

  // divide set-up: numerator 2|p| + 2r, divisor 4r
  dv_t d0;
  always_comb begin
    d0.vld = pr.vld;
    d0.zero = pr.zero;
    d0.w = pr.w;
    d0.dvs = {pr.r, 2'b00};
    d0.q = '0;
    for (int i = 0; i < 3; i++) begin
      d0.neg[i] = pr.p[i][47];
      d0.rem[i] = ({1'b0, (pr.p[i][47] ? -pr.p[i] : pr.p[i])} << 1) + 49'({pr.r, 1'b0});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0].vld <= 1'b0;
    end else if (en) begin
      dv[0] <= d0;
    end
  end

  for (genvar j = 0; j < NQ; j++) begin : g_dv
    localparam int QB = NQ - 1 - j;
    dv_t nx;
    logic [49:0] trial;
    always_comb begin
      nx = dv[j];
      trial = 50'(dv[j].dvs) << QB;
      for (int i = 0; i < 3; i++) begin
        if (50'(dv[j].rem[i]) >= trial) begin
          nx.rem[i] = 49'(50'(dv[j].rem[i]) - trial);
          nx.q[i][QB] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[j+1].vld <= 1'b0;
      end else if (en) begin
        dv[j+1] <= nx;
      end
    end
  end

  // clamp, sign and zero-axis forcing
  ot_t on;
  logic [15:0] qc;
  always_comb begin
    on.vld = dv[NQ].vld;
    on.zero = dv[NQ].zero;
    on.q[3] = dv[NQ].w;
    for (int i = 0; i < 3; i++) begin
      qc = (dv[NQ].q[i] > aaq_pkg::ONE_Q14) ? 16'(aaq_pkg::ONE_Q14) : dv[NQ].q[i][15:0];
      if (dv[NQ].neg[i]) begin
        qc = -qc;
      end
      on.q[i] = dv[NQ].zero ? 16'd0 : qc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ot.vld <= 1'b0;
    end else if (en) begin
      ot <= on;
    end
  end

  assign res.valid = ot.vld;
  assign res.quat_x = ot.q[0];
  assign res.quat_y = ot.q[1];
  assign res.quat_z = ot.q[2];
  assign res.quat_w = ot.q[3];
  assign res.zero_axis = ot.zero;

  // a zero axis leaves no vector part
  a_zero_vec: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.zero_axis |-> res.quat_x == 16'sd0 && res.quat_y == 16'sd0 &&
    res.quat_z == 16'sd0)
    else $error("vector part not zero for zero axis");

  // scalar part stays within unit range
  a_w_range: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> res.quat_w <= 16'sd16384 && res.quat_w >= -16'sd16384)
    else $error("quat_w out of range");

  // an accepted item lands in the front stage
  a_front: assert property (@(posedge clk) disable iff (rst)
    cmd.valid && cmd.ready |=> fr.vld)
    else $error("accepted item lost at front stage");

  // a stalled pipe freezes the iteration chain
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(it[NS]) && $stable(pr))
    else $error("pipe moved during stall");

endmodule
`default_nettype wire
